// File: design/rdre_pkg.sv
package rdre_pkg;

    localparam logic [7:0] RUN_LIMIT = 8'd255;
    localparam int OUTQ_DEPTH = 4;

    typedef enum logic {
        KIND_RAW  = 1'b0,
        KIND_PAIR = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t item_kind;
        logic [7:0] skip_run;
        logic [7:0] payload;
        logic       record_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       first;
        logic       rec_delta;
        logic       rec_hist;
    } stage_t;

endpackage

// File: design/rdre_ram.sv
module rdre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/rdre_outq.sv
module rdre_outq
    import rdre_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_vld,
    input  out_item_t  push_item0,
    input  out_item_t  push_item1,
    output logic [2:0] count,
    output logic       pop_vld,
    input  logic       pop_rdy,
    output out_item_t  pop_item
);

    out_item_t  q_reg [OUTQ_DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [2:0] n_push;
    logic       pop;

    assign pop     = (count_reg != 3'd0) && pop_rdy;
    assign n_push  = {2'b00, push_vld[0]} + {2'b00, push_vld[1]};
    assign wr_ptr_next = wr_ptr_reg + n_push[1:0];
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + n_push - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (push_vld[0]) begin
            q_reg[wr_ptr_reg] <= push_item0;
        end
        if (push_vld[1]) begin
            q_reg[wr_ptr_reg + 2'd1] <= push_item1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign count    = count_reg;
    assign pop_vld  = count_reg != 3'd0;
    assign pop_item = q_reg[rd_ptr_reg];

endmodule

// File: design/record_delta_run_encoder.sv
// Record delta run encoder.
// Input channel s_*: one record byte per beat with its record length and a
// last-byte flag. Output channel m_*: raw bytes, or (skip_run, delta) pairs
// against the previous record of the same length, delta = old - new mod 256.
// Config channel cfg_*: one-bit output_format, always ready; write only while
// idle. The format is sampled at the first byte of each record.
// History is kept in one RAM of HISTORY_SLOTS * MAX_LEN bytes, read at accept
// and written back as the byte leaves stage 1; a same-entry write/read pair is
// forwarded.
// Throughput: one byte per cycle, set by one history read and one write-back
// per cycle and by the output queue. A byte yields zero, one or two result
// beats; the output drains one beat per cycle, so bursts of two-beat bytes
// slow acceptance.
// A byte is registered in stage 1, and its result beats are then written into
// the output queue before m_valid shows them; the byte can wait in stage 1.
// Reset clears the slot table, replacement pointer, counters and the output
// queue; the history RAM needs no clearing. When m_ready is low, results
// collect in a four-beat output queue; while it holds three or more beats a
// byte waits in stage 1 and s_ready drops.
module record_delta_run_encoder
    import rdre_pkg::*;
#(
    parameter int MAX_LEN       = 256,
    parameter int HISTORY_SLOTS = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic [8:0] s_record_length,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_item_kind,
    output logic [7:0] m_skip_run,
    output logic [7:0] m_payload,
    output logic       m_record_end
);

    localparam int SLOT_W = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int DEPTH  = HISTORY_SLOTS * MAX_LEN;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                   fmt_reg;
    logic [HISTORY_SLOTS-1:0] slot_valid_reg;
    logic [8:0]             slot_length_reg [HISTORY_SLOTS];
    logic [SLOT_W-1:0]      replace_ptr_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [SLOT_W-1:0]      active_slot_reg;
    logic                   rec_delta_reg;
    logic                   rec_hist_reg;
    logic [7:0]             run_reg;

    logic                   s1_vld_reg;
    stage_t                 s1_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic                   fwd_reg;
    logic [7:0]             fwd_byte_reg;

    logic                   accept;
    logic                   first0;
    logic                   hit;
    logic [SLOT_W-1:0]      hit_idx;
    logic                   has_free;
    logic [SLOT_W-1:0]      free_idx;
    logic [SLOT_W-1:0]      alloc_idx;
    logic [SLOT_W-1:0]      cur_slot;
    logic                   cur_delta;
    logic                   cur_hist;
    logic [ADDR_W-1:0]      addr0;
    stage_t                 s0_item;

    logic                   s1_adv;
    logic                   mem_we;
    logic [7:0]             rdata;
    logic [7:0]             old_byte;
    logic [7:0]             delta;
    logic [7:0]             run_base;
    logic [7:0]             run_after;
    logic [7:0]             run_next;
    logic                   close_pair;
    logic [1:0]             push_vld;
    out_item_t              push_item0;
    out_item_t              push_item1;
    logic [2:0]             q_count;
    out_item_t              pop_item;

    assign cfg_ready = 1'b1;

    // slot lookup, first matching slot wins
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int s = HISTORY_SLOTS - 1; s >= 0; s--) begin
            if (slot_valid_reg[s] && (slot_length_reg[s] == s_record_length)) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(s);
            end
            if (!slot_valid_reg[s]) begin
                has_free = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
        alloc_idx = has_free ? free_idx : replace_ptr_reg;
    end

    assign s1_adv = s1_vld_reg && (q_count <= 3'd2);
    assign s_ready = !s1_vld_reg || s1_adv;
    assign accept  = s_valid && s_ready;
    assign first0  = pos_reg == '0;

    assign cur_delta = first0 ? fmt_reg : rec_delta_reg;
    assign cur_hist  = first0 ? (fmt_reg && hit) : rec_hist_reg;
    always_comb begin
        if (first0 && fmt_reg) begin
            cur_slot = hit ? hit_idx : alloc_idx;
        end else begin
            cur_slot = active_slot_reg;
        end
    end
    assign addr0 = ADDR_W'(cur_slot) * ADDR_W'(MAX_LEN) + ADDR_W'(pos_reg);

    assign s0_item = '{data_byte: s_data_byte, last_byte: s_last_byte, first: first0,
                       rec_delta: cur_delta, rec_hist: cur_hist};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg         <= 1'b0;
            slot_valid_reg  <= '0;
            replace_ptr_reg <= '0;
            pos_reg         <= '0;
            active_slot_reg <= '0;
            rec_delta_reg   <= 1'b0;
            rec_hist_reg    <= 1'b0;
            s1_vld_reg      <= 1'b0;
            for (int s = 0; s < HISTORY_SLOTS; s++) begin
                slot_length_reg[s] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                fmt_reg <= cfg_data[0];
            end
            if (accept) begin
                s1_vld_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_vld_reg <= 1'b0;
            end
            if (accept) begin
                if (s_last_byte || (pos_reg == POS_W'(MAX_LEN - 1))) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
                if (first0) begin
                    rec_delta_reg <= fmt_reg;
                    rec_hist_reg  <= fmt_reg && hit;
                    if (fmt_reg) begin
                        active_slot_reg <= cur_slot;
                        if (!hit) begin
                            slot_valid_reg[alloc_idx]  <= 1'b1;
                            slot_length_reg[alloc_idx] <= s_record_length;
                            if (!has_free) begin
                                if (replace_ptr_reg == SLOT_W'(HISTORY_SLOTS - 1)) begin
                                    replace_ptr_reg <= '0;
                                end else begin
                                    replace_ptr_reg <= replace_ptr_reg + SLOT_W'(1);
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // stage 1 payload and write-to-read forwarding
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg       <= s0_item;
            s1_addr_reg  <= addr0;
            fwd_reg      <= mem_we && (s1_addr_reg == addr0);
            fwd_byte_reg <= s1_reg.data_byte;
        end
    end

    assign mem_we = s1_adv && s1_reg.rec_delta;

    rdre_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_hist (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(s1_addr_reg),
        .wdata(s1_reg.data_byte),
        .re   (accept),
        .raddr(addr0),
        .rdata(rdata)
    );

    assign old_byte   = fwd_reg ? fwd_byte_reg : rdata;
    assign delta      = old_byte - s1_reg.data_byte;
    assign run_base   = s1_reg.first ? 8'd0 : run_reg;
    assign close_pair = (delta != 8'd0) || (run_base == RUN_LIMIT);
    assign run_after  = close_pair ? 8'd0 : run_base + 8'd1;
    assign run_next   = s1_reg.last_byte ? 8'd0 : run_after;

    always_comb begin
        push_vld   = 2'b00;
        push_item0 = '{item_kind: KIND_RAW, skip_run: 8'd0, payload: s1_reg.data_byte,
                       record_end: s1_reg.last_byte};
        push_item1 = '{item_kind: KIND_PAIR, skip_run: run_after, payload: 8'd0,
                       record_end: 1'b1};
        if (s1_adv) begin
            if (!(s1_reg.rec_delta && s1_reg.rec_hist)) begin
                push_vld = 2'b01;
            end else if (close_pair) begin
                push_item0 = '{item_kind: KIND_PAIR, skip_run: run_base, payload: delta,
                               record_end: 1'b0};
                push_vld   = s1_reg.last_byte ? 2'b11 : 2'b01;
            end else if (s1_reg.last_byte) begin
                push_item0 = push_item1;
                push_vld   = 2'b01;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else if (s1_adv) begin
            run_reg <= run_next;
        end
    end

    rdre_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_vld  (push_vld),
        .push_item0(push_item0),
        .push_item1(push_item1),
        .count     (q_count),
        .pop_vld   (m_valid),
        .pop_rdy   (m_ready),
        .pop_item  (pop_item)
    );

    assign m_item_kind  = pop_item.item_kind;
    assign m_skip_run   = pop_item.skip_run;
    assign m_payload    = pop_item.payload;
    assign m_record_end = pop_item.record_end;

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_vld_reg)
        else $error("accepted beat did not reach stage 1");

    a_slot_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ((slot_valid_reg & $past(slot_valid_reg)) == $past(slot_valid_reg)))
        else $error("slot valid bit cleared");

    a_hist_needs_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && s1_reg.rec_hist) |-> s1_reg.rec_delta)
        else $error("history without delta format");

    a_active_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(active_slot_reg) < HISTORY_SLOTS)
        else $error("active slot out of range");

endmodule

// File: tb/sv/record_delta_run_encoder_tb.sv
module record_delta_run_encoder_tb;
    import rdre_pkg::*;

    localparam int MAX_LEN = 256;
    localparam int SLOTS   = 4;

    class record_delta_predictor;
        bit          fmt;
        bit          rec_delta;
        bit          rec_hist;
        logic [7:0]  hist [0:SLOTS*MAX_LEN-1];
        bit          written [0:SLOTS*MAX_LEN-1];
        logic [8:0]  slot_len [0:SLOTS-1];
        bit          slot_ok [0:SLOTS-1];
        logic [1:0]  repl;
        logic [7:0]  run;
        logic [7:0]  pos;
        logic [1:0]  act;
        out_item_t   pending_items [$];
        int          errors;
        int          n_bytes;
        int          n_raw;
        int          n_pair;
        int          n_cap;
        int          n_evict;

        function new();
            fmt = 0;
            rec_delta = 0;
            rec_hist = 0;
            repl = 0;
            run = 0;
            pos = 0;
            act = 0;
            errors = 0;
            n_bytes = 0;
            n_raw = 0;
            n_pair = 0;
            n_cap = 0;
            n_evict = 0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_len[i] = 0;
                slot_ok[i] = 0;
            end
        endfunction

        function void set_format(bit v);
            fmt = v;
        endfunction

        function int pending();
            return pending_items.size();
        endfunction

        function int find_slot(logic [8:0] len);
            for (int i = 0; i < SLOTS; i++)
                if (slot_ok[i] && slot_len[i] == len)
                    return i;
            return -1;
        endfunction

        // positions of the matching slot written so far, counted from 0; -1 if
        // the next record would go out raw without a lookup hit
        function int hit_depth(logic [8:0] len, output int slot);
            int d;
            slot = find_slot(len);
            if (!fmt || slot < 0)
                return -1;
            d = 0;
            while (d < MAX_LEN && written[slot*MAX_LEN + d])
                d++;
            return d;
        endfunction

        function logic [7:0] stored_byte(int slot, int p);
            return hist[slot*MAX_LEN + p];
        endfunction

        function void push(item_kind_t kind, logic [7:0] r, logic [7:0] pay, logic fin);
            out_item_t it;
            it.item_kind = kind;
            it.skip_run = r;
            it.payload = pay;
            it.record_end = fin;
            pending_items.insert(pending_items.size(), it);
            if (kind == KIND_RAW)
                n_raw++;
            else
                n_pair++;
        endfunction

        function void open_record(logic [8:0] len);
            int s;
            rec_delta = fmt;
            rec_hist = 0;
            run = 0;
            if (!rec_delta)
                return;
            s = find_slot(len);
            if (s >= 0) begin
                act = 2'(s);
                rec_hist = 1;
                return;
            end
            for (int i = 0; i < SLOTS; i++)
                if (!slot_ok[i] && s < 0)
                    s = i;
            if (s < 0) begin
                s = int'(repl);
                repl = repl + 1'b1;
                n_evict++;
            end
            act = 2'(s);
            slot_ok[s] = 1;
            slot_len[s] = len;
        endfunction

        function void note_byte(logic [7:0] b, logic [8:0] len, logic last);
            int addr;
            logic [7:0] d;
            n_bytes++;
            if (pos == 0)
                open_record(len);
            addr = int'(act) * MAX_LEN + int'(pos);
            if (!rec_delta || !rec_hist) begin
                push(KIND_RAW, 8'd0, b, last);
            end else begin
                d = hist[addr] - b;
                if (d != 0 || run == RUN_LIMIT) begin
                    if (run == RUN_LIMIT)
                        n_cap++;
                    push(KIND_PAIR, run, d, 1'b0);
                    run = 0;
                end else begin
                    run = run + 1'b1;
                end
                if (last)
                    push(KIND_PAIR, run, 8'd0, 1'b1);
            end
            if (rec_delta) begin
                hist[addr] = b;
                written[addr] = 1;
            end
            if (last) begin
                pos = 0;
                run = 0;
            end else begin
                pos = pos + 1'b1;
            end
        endfunction

        function void check_result(logic kind, logic [7:0] r, logic [7:0] pay, logic fin);
            out_item_t want;
            if (pending_items.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result kind=%0d run=%0d payload=%02h end=%0d",
                             $time, kind, r, pay, fin);
                return;
            end
            want = pending_items.pop_front();
            if (kind !== want.item_kind || r !== want.skip_run ||
                pay !== want.payload || fin !== want.record_end) begin
                errors++;
                if (errors <= 10) begin
                    $write("%0t: mismatch: expected kind=%0d run=%0d payload=%02h end=%0d,",
                           $time, want.item_kind, want.skip_run, want.payload,
                           want.record_end);
                    $display(" got kind=%0d run=%0d payload=%02h end=%0d",
                             kind, r, pay, fin);
                end
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_data = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'd0;
    logic [8:0] s_record_length = 9'd1;
    logic       s_last_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_item_kind;
    logic [7:0] m_skip_run;
    logic [7:0] m_payload;
    logic       m_record_end;

    int idle_pct = 0;
    int stall_pct = 0;
    int short_lens [0:5] = '{1, 2, 3, 4, 7, 12};

    record_delta_predictor pred;

    record_delta_run_encoder uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_record_length(s_record_length),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item_kind    (m_item_kind),
        .m_skip_run     (m_skip_run),
        .m_payload      (m_payload),
        .m_record_end   (m_record_end)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                pred.set_format(cfg_data[0]);
            if (s_valid && s_ready)
                pred.note_byte(s_data_byte, s_record_length, s_last_byte);
            if (m_valid && m_ready)
                pred.check_result(m_item_kind, m_skip_run, m_payload, m_record_end);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [8:0] len, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_record_length <= len;
        s_last_byte <= last;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pred.pending() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_format(input bit v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // content follows the stored history so runs form; mut is the percent of
    // bytes replaced by random values
    task automatic send_record(input int len, input int cnt, input int mut, output int n);
        int depth;
        int slot;
        logic [8:0] len9;
        logic [7:0] b;
        logic [7:0] plan [$];
        len9 = 9'(len);
        depth = pred.hit_depth(len9, slot);
        if (depth >= 0 && depth < MAX_LEN && cnt > depth)
            cnt = depth;
        for (int p = 0; p < cnt; p++) begin
            if (depth < 0 || $urandom_range(99) < mut)
                b = 8'($urandom_range(255));
            else if (p < MAX_LEN)
                b = pred.stored_byte(slot, p);
            else
                b = plan[p - MAX_LEN];
            plan.insert(plan.size(), b);
        end
        for (int p = 0; p < cnt; p++)
            send_byte(plan[p], len9, p == cnt - 1);
        n = cnt;
    endtask

    task automatic run_random(input int budget);
        int sent;
        int n;
        int r;
        int len;
        int cnt;
        int mut;
        sent = 0;
        while (sent < budget) begin
            r = $urandom_range(99);
            if (r < 2)
                len = MAX_LEN;
            else if (r < 10)
                len = $urandom_range(1, 40);
            else
                len = short_lens[$urandom_range(5)];
            cnt = len;
            r = $urandom_range(99);
            if (r < 8)
                cnt = len + $urandom_range(1, 3);
            else if (r < 16 && len > 1)
                cnt = len - 1;
            else if (r < 30 && len == MAX_LEN)
                cnt = len + $urandom_range(1, 40);
            case ($urandom_range(4))
                0, 1: mut = 0;
                2: mut = 5;
                3: mut = 30;
                default: mut = 100;
            endcase
            send_record(len, cnt, mut, n);
            sent += n;
        end
    endtask

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int n;
        pred = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_format(1'b0);
        send_byte(8'h00, 9'd3, 1'b0);
        send_byte(8'hFF, 9'd3, 1'b0);
        send_byte(8'h5A, 9'd3, 1'b1);

        write_format(1'b1);
        send_byte(8'd10, 9'd4, 1'b0);
        send_byte(8'd20, 9'd4, 1'b0);
        send_byte(8'd30, 9'd4, 1'b0);
        send_byte(8'd40, 9'd4, 1'b1);
        send_byte(8'd10, 9'd4, 1'b0);
        send_byte(8'd21, 9'd4, 1'b0);
        send_byte(8'd30, 9'd4, 1'b0);
        send_byte(8'd40, 9'd4, 1'b1);
        // delta on the last byte: closed pair, then the flush
        send_byte(8'hFF, 9'd4, 1'b0);
        send_byte(8'd21, 9'd4, 1'b0);
        send_byte(8'd30, 9'd4, 1'b0);
        send_byte(8'd41, 9'd4, 1'b1);
        // declared length shorter than the byte count
        send_byte(8'd7, 9'd2, 1'b0);
        send_byte(8'd8, 9'd2, 1'b0);
        send_byte(8'd9, 9'd2, 1'b1);
        send_byte(8'd7, 9'd2, 1'b0);
        send_byte(8'd8, 9'd2, 1'b0);
        send_byte(8'd9, 9'd2, 1'b1);
        send_byte(8'hA5, 9'd1, 1'b1);
        send_byte(8'hA5, 9'd1, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 88 : (ph == 3) ? 26 : 0;
            stall_pct = (ph == 2) ? 88 : (ph == 3) ? 26 : 0;
            write_format(1'b1);
            if (ph == 0) begin
                // full-length record, then an identical one to hit the run cap
                send_record(MAX_LEN, MAX_LEN, 0, n);
                send_record(MAX_LEN, MAX_LEN, 0, n);
            end
            run_random(60);
            write_format(1'b0);
            run_random(20);
        end

        s_valid <= 1'b0;
        while (pred.pending() != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("Sent %0d bytes in raw and delta format over four flow-control phases;",
                 pred.n_bytes);
        $display("checked %0d raw and %0d pair beats, %0d run-cap closes, %0d slot evictions",
                 pred.n_raw, pred.n_pair, pred.n_cap, pred.n_evict);
        if (pred.errors == 0 && pred.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
